### design/tga_rle_pkg.sv
// Shared types, constants and helper functions for the run-length coded targa pixel decoder.
// Depends on nothing; every other design file imports it.
`default_nettype none

package tga_rle_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned FORMAT_W   = 2;
    localparam int unsigned PIXELS_W   = 32;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned HELD_W     = 24;
    localparam int unsigned IDX_W      = 2;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_FORMAT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_PIXELS = 1'b1;

    localparam logic [FORMAT_W-1:0] FMT_MONO = 2'd0;
    localparam logic [FORMAT_W-1:0] FMT_RGB  = 2'd1;

    localparam logic [FORMAT_W-1:0] FORMAT_RESET       = FMT_RGB;
    localparam logic [PIXELS_W-1:0] IMAGE_PIXELS_RESET = 32'd1;

    localparam int unsigned     RUN_FLAG_BIT = 7;
    localparam logic [6:0]      COUNT_MASK   = 7'h7F;
    localparam logic [COUNT_W-1:0] MAX_RUN   = 8'd128;

    typedef struct packed {
        logic [FORMAT_W-1:0] pixel_format;
        logic [PIXELS_W-1:0] image_pixels;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  chan0;
        logic [BYTE_W-1:0]  chan1;
        logic [BYTE_W-1:0]  chan2;
        logic [BYTE_W-1:0]  chan3;
        logic [COUNT_W-1:0] repeat_count;
        logic               image_done;
    } pixel_t;

    // Index of the byte that completes a pixel; format code three acts as four-byte mode.
    function automatic logic [IDX_W-1:0] last_byte_index(input logic [FORMAT_W-1:0] fmt);
        logic [IDX_W-1:0] idx;
        case (fmt)
            FMT_MONO: idx = 2'd0;
            FMT_RGB:  idx = 2'd2;
            default:  idx = 2'd3;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

### design/tga_rle_if.sv
// Handshake interfaces for the byte stream, the decoded pixel stream and the configuration writes.
// Depends on tga_rle_pkg.
`default_nettype none

interface tga_rle_byte_if;
    import tga_rle_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface tga_rle_pix_if;
    import tga_rle_pkg::*;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  chan0;
    logic [BYTE_W-1:0]  chan1;
    logic [BYTE_W-1:0]  chan2;
    logic [BYTE_W-1:0]  chan3;
    logic [COUNT_W-1:0] repeat_count;
    logic               image_done;
    modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                    output repeat_count, output image_done, input ready);
    modport sink (input valid, input chan0, input chan1, input chan2, input chan3,
                  input repeat_count, input image_done, output ready);
endinterface

interface tga_rle_cfg_if;
    import tga_rle_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

### design/tga_rle_cfg_regs.sv
// Configuration registers for pixel format and image size, written over the configuration channel.
// Depends on tga_rle_pkg and tga_rle_if.
`default_nettype none

module tga_rle_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    tga_rle_cfg_if.sink        cfg,
    output tga_rle_pkg::cfg_t  cfg_out
);
    import tga_rle_pkg::*;

    logic [FORMAT_W-1:0] pixel_format_reg;
    logic [PIXELS_W-1:0] image_pixels_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= FORMAT_RESET;
            image_pixels_reg <= IMAGE_PIXELS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_PIXEL_FORMAT: pixel_format_reg <= cfg.data[FORMAT_W-1:0];
                CFG_IMAGE_PIXELS: image_pixels_reg <= cfg.data[PIXELS_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_out.pixel_format = pixel_format_reg;
    assign cfg_out.image_pixels = image_pixels_reg;

endmodule

`default_nettype wire

### design/tga_rle_core.sv
// Input register, packet and pixel state, and the single-pass decode of one stream byte.
// Depends on tga_rle_pkg and tga_rle_if.
`default_nettype none

module tga_rle_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    tga_rle_byte_if.sink        stream,
    input  wire tga_rle_pkg::cfg_t cfg,
    input  wire logic           res_ready,
    output logic                res_valid,
    output tga_rle_pkg::pixel_t res
);
    import tga_rle_pkg::*;

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                expect_header_reg, expect_header_next;
    logic                packet_is_run_reg, packet_is_run_next;
    logic [COUNT_W-1:0]  packet_left_reg, packet_left_next;
    logic [IDX_W-1:0]    byte_idx_reg, byte_idx_next;
    logic [HELD_W-1:0]   held_reg, held_next;
    logic [PIXELS_W-1:0] emitted_reg, emitted_next;

    logic                proc;
    logic [IDX_W-1:0]    last_idx;
    logic [COUNT_W-1:0]  count;
    logic [COUNT_W-1:0]  left_after;
    logic                below;
    logic [PIXELS_W-1:0] remaining;
    logic                count_covers;
    logic [COUNT_W-1:0]  rep;
    logic                emit_ok;
    logic                done_chk;

    assign proc         = in_valid_reg && res_ready;
    assign stream.ready = !in_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg <= stream.stream_byte;
        end
    end

    assign last_idx = last_byte_index(cfg.pixel_format);

    always_comb
    begin
        count = packet_is_run_reg ? packet_left_reg : COUNT_W'(1);
        if (count > packet_left_reg)
        begin
            count = packet_left_reg;
        end
    end

    assign left_after   = packet_left_reg - count;
    assign below        = emitted_reg < cfg.image_pixels;
    assign remaining    = cfg.image_pixels - emitted_reg;
    assign count_covers = PIXELS_W'(count) >= remaining;
    assign rep          = count_covers ? remaining[COUNT_W-1:0] : count;
    assign emit_ok      = (count != '0) && below;
    assign done_chk     = emit_ok ? count_covers : !below;

    always_comb
    begin
        expect_header_next = expect_header_reg;
        packet_is_run_next = packet_is_run_reg;
        packet_left_next   = packet_left_reg;
        byte_idx_next      = byte_idx_reg;
        held_next          = held_reg;
        emitted_next       = emitted_reg;
        res_valid          = 1'b0;
        if (proc)
        begin
            if (expect_header_reg)
            begin
                packet_is_run_next = in_byte_reg[RUN_FLAG_BIT];
                packet_left_next   = {1'b0, in_byte_reg[6:0] & COUNT_MASK} + COUNT_W'(1);
                byte_idx_next      = '0;
                expect_header_next = 1'b0;
            end
            else if (byte_idx_reg < last_idx)
            begin
                case (byte_idx_reg)
                    2'd0:    held_next[7:0]   = in_byte_reg;
                    2'd1:    held_next[15:8]  = in_byte_reg;
                    2'd2:    held_next[23:16] = in_byte_reg;
                    default: ;
                endcase
                byte_idx_next = byte_idx_reg + IDX_W'(1);
            end
            else
            begin
                byte_idx_next    = '0;
                packet_left_next = left_after;
                if (emit_ok)
                begin
                    emitted_next = emitted_reg + PIXELS_W'(rep);
                    res_valid    = 1'b1;
                end
                if (left_after == '0)
                begin
                    expect_header_next = 1'b1;
                    if (done_chk)
                    begin
                        emitted_next = '0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        case (last_idx)
            2'd0:
            begin
                res.chan0 = in_byte_reg;
                res.chan1 = '0;
                res.chan2 = '0;
                res.chan3 = '0;
            end
            2'd2:
            begin
                res.chan0 = in_byte_reg;
                res.chan1 = held_reg[15:8];
                res.chan2 = held_reg[7:0];
                res.chan3 = '0;
            end
            default:
            begin
                res.chan0 = held_reg[23:16];
                res.chan1 = held_reg[15:8];
                res.chan2 = held_reg[7:0];
                res.chan3 = in_byte_reg;
            end
        endcase
        res.repeat_count = rep;
        res.image_done   = count_covers;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            packet_left_reg   <= '0;
            byte_idx_reg      <= '0;
            held_reg          <= '0;
            emitted_reg       <= '0;
        end
        else
        begin
            expect_header_reg <= expect_header_next;
            packet_is_run_reg <= packet_is_run_next;
            packet_left_reg   <= packet_left_next;
            byte_idx_reg      <= byte_idx_next;
            held_reg          <= held_next;
            emitted_reg       <= emitted_next;
        end
    end

    // A decoded pixel always covers at least one and at most one full run of image pixels.
    a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.repeat_count != '0) && (res.repeat_count <= MAX_RUN))
        else $error("repeat count out of range");

    // A header byte never produces a pixel.
    a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
        proc && expect_header_reg |-> !res_valid)
        else $error("pixel emitted on a header byte");

    // Inside a packet at least one pixel is still owed.
    a_packet_open: assert property (@(posedge clk) disable iff (!rst_n)
        !expect_header_reg |-> packet_left_reg != '0)
        else $error("open packet with no pixels left");

    // A held byte that cannot move on stays in the input register.
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !res_ready |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte lost while stalled");

endmodule

`default_nettype wire

### design/tga_rle_out_stage.sv
// Result register that holds one decoded pixel until the pixel channel takes it.
// Depends on tga_rle_pkg and tga_rle_if.
`default_nettype none

module tga_rle_out_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           res_valid,
    input  wire tga_rle_pkg::pixel_t res,
    output logic                res_ready,
    tga_rle_pix_if.source       pixel
);
    import tga_rle_pkg::*;

    logic   out_valid_reg;
    pixel_t out_data_reg;

    assign res_ready = !out_valid_reg || pixel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.chan0        = out_data_reg.chan0;
    assign pixel.chan1        = out_data_reg.chan1;
    assign pixel.chan2        = out_data_reg.chan2;
    assign pixel.chan3        = out_data_reg.chan3;
    assign pixel.repeat_count = out_data_reg.repeat_count;
    assign pixel.image_done   = out_data_reg.image_done;

endmodule

`default_nettype wire

### design/tga_rle_pixel_decoder.sv
// A pixel passes from the input register through the result register to the pixel channel
// after its last byte is transferred; a stall on the pixel channel can hold it in between.
// One stream byte per cycle when not stalled; packet and pixel counters update in one pass.
// Stalls on the pixel channel hold the input register and back up the stream channel.
// Reset clears the packet state and counters; pixel format resets to three-byte colour
// and the image size to one pixel. No memory, so no clearing pass is needed.
`default_nettype none

module tga_rle_pixel_decoder (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tga_rle_byte_if.sink  stream,
    tga_rle_pix_if.source pixel,
    tga_rle_cfg_if.sink   cfg
);
    import tga_rle_pkg::*;

    cfg_t   cfg_q;
    logic   res_valid;
    logic   res_ready;
    pixel_t res;

    tga_rle_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_q)
    );

    tga_rle_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .cfg       (cfg_q),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    tga_rle_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .pixel     (pixel)
    );

endmodule

`default_nettype wire

### tb/sv/tga_rle_pixel_decoder_sb_pkg.sv
// Scoreboard class for the run-length coded targa pixel decoder testbench.
// It predicts decoded pixels from the transferred stream bytes and checks the results.
// Depends on tga_rle_pkg.
`timescale 1ns / 100ps

package tga_rle_pixel_decoder_sb_pkg;
    import tga_rle_pkg::*;

    class decoded_pixel_checker;
        logic [FORMAT_W-1:0] fmt;
        logic [PIXELS_W-1:0] image_size;
        bit                  want_header;
        bit                  run_packet;
        logic [COUNT_W-1:0]  pixels_left;
        logic [IDX_W-1:0]    byte_idx;
        logic [HELD_W-1:0]   held_bytes;
        logic [PIXELS_W-1:0] emitted;
        pixel_t              expected_pixels[$];
        int                  errors;
        int                  bytes_seen;
        int                  pixels_checked;
        int                  reg_writes;

        function new();
            fmt            = FORMAT_RESET;
            image_size     = IMAGE_PIXELS_RESET;
            want_header    = 1'b1;
            run_packet     = 1'b0;
            pixels_left    = '0;
            byte_idx       = '0;
            held_bytes     = '0;
            emitted        = '0;
            errors         = 0;
            bytes_seen     = 0;
            pixels_checked = 0;
            reg_writes     = 0;
        endfunction

        function void set_reg(input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] data);
            if (addr == CFG_PIXEL_FORMAT)
            begin
                fmt = data[FORMAT_W-1:0];
            end
            else
            begin
                image_size = data[PIXELS_W-1:0];
            end
            reg_writes++;
        endfunction

        function void note_byte(input logic [BYTE_W-1:0] b);
            logic [IDX_W-1:0]    last;
            logic [COUNT_W-1:0]  count;
            logic [PIXELS_W-1:0] rep;
            pixel_t              px;
            bytes_seen++;
            if (want_header)
            begin
                run_packet  = b[RUN_FLAG_BIT];
                pixels_left = {1'b0, b[6:0]} + 8'd1;
                byte_idx    = '0;
                want_header = 1'b0;
                return;
            end
            last = (fmt == FMT_MONO) ? 2'd0 : (fmt == FMT_RGB) ? 2'd2 : 2'd3;
            if (byte_idx < last)
            begin
                held_bytes[8*byte_idx +: 8] = b;
                byte_idx = byte_idx + 2'd1;
                return;
            end
            byte_idx = '0;
            px = '0;
            if (last == 2'd0)
            begin
                px.chan0 = b;
            end
            else if (last == 2'd2)
            begin
                px.chan0 = b;
                px.chan1 = held_bytes[15:8];
                px.chan2 = held_bytes[7:0];
            end
            else
            begin
                px.chan0 = held_bytes[23:16];
                px.chan1 = held_bytes[15:8];
                px.chan2 = held_bytes[7:0];
                px.chan3 = b;
            end
            count = run_packet ? pixels_left : 8'd1;
            if (count > pixels_left)
            begin
                count = pixels_left;
            end
            pixels_left = pixels_left - count;
            if (count != 0 && emitted < image_size)
            begin
                rep = image_size - emitted;
                if (count < rep)
                begin
                    rep = count;
                end
                emitted = emitted + rep;
                px.repeat_count = rep[COUNT_W-1:0];
                px.image_done   = (emitted >= image_size);
                expected_pixels.push_back(px);
            end
            if (pixels_left == 0)
            begin
                want_header = 1'b1;
                if (emitted >= image_size)
                begin
                    emitted = '0;
                end
            end
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_pixel(input pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("pixel %h %h %h %h rep %0d done %0b with none expected",
                                 got.chan0, got.chan1, got.chan2, got.chan3,
                                 got.repeat_count, got.image_done));
                return;
            end
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (got.chan0 !== want.chan0)
                report($sformatf("pixel %0d chan0 %h, expected %h",
                                 pixels_checked, got.chan0, want.chan0));
            if (got.chan1 !== want.chan1)
                report($sformatf("pixel %0d chan1 %h, expected %h",
                                 pixels_checked, got.chan1, want.chan1));
            if (got.chan2 !== want.chan2)
                report($sformatf("pixel %0d chan2 %h, expected %h",
                                 pixels_checked, got.chan2, want.chan2));
            if (got.chan3 !== want.chan3)
                report($sformatf("pixel %0d chan3 %h, expected %h",
                                 pixels_checked, got.chan3, want.chan3));
            if (got.repeat_count !== want.repeat_count)
                report($sformatf("pixel %0d repeat_count %0d, expected %0d",
                                 pixels_checked, got.repeat_count, want.repeat_count));
            if (got.image_done !== want.image_done)
                report($sformatf("pixel %0d image_done %0b, expected %0b",
                                 pixels_checked, got.image_done, want.image_done));
        endtask
    endclass

endpackage

### tb/sv/tga_rle_pixel_decoder_tb.sv
// Top-level testbench for the run-length coded targa pixel decoder: directed packets,
// then random packet streams under several register settings with random idling.
// Depends on tga_rle_pkg, the handshake interfaces and tga_rle_pixel_decoder_sb_pkg.
`timescale 1ns / 100ps

module tga_rle_pixel_decoder_tb;
    import tga_rle_pkg::*;
    import tga_rle_pixel_decoder_sb_pkg::*;

    localparam int unsigned         STIMULUS_BYTES = 1900;
    localparam int unsigned         SETTLE_CYCLES  = 6;
    localparam logic [FORMAT_W-1:0] FMT_RGBA       = 2'd2;
    localparam logic [FORMAT_W-1:0] FMT_CODE3      = 2'd3;
    localparam logic [PIXELS_W-1:0] SIZE_MAX       = 32'd4294836225;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct = 10;

    decoded_pixel_checker sb = new();

    tga_rle_byte_if stream_if();
    tga_rle_pix_if  pixel_if();
    tga_rle_cfg_if  cfg_if();

    tga_rle_pixel_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stream(stream_if.sink),
        .pixel (pixel_if.source),
        .cfg   (cfg_if.sink)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        pixel_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            pixel_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pixel_if.valid && pixel_if.ready)
        begin
            sb.check_pixel(pixel_t'{pixel_if.chan0, pixel_if.chan1, pixel_if.chan2,
                                    pixel_if.chan3, pixel_if.repeat_count,
                                    pixel_if.image_done});
        end
    end

    function automatic logic [BYTE_W-1:0] random_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            stream_if.valid <= 1'b0;
            @(negedge clk);
        end
        stream_if.valid       <= 1'b1;
        stream_if.stream_byte <= b;
        @(posedge clk);
        while (!stream_if.ready)
        begin
            @(posedge clk);
        end
        sb.note_byte(b);
        @(negedge clk);
    endtask

    task automatic send_packet(input bit run, input logic [6:0] n_minus1);
        int bpp;
        int n_bytes;
        bpp     = (sb.fmt == FMT_MONO) ? 1 : (sb.fmt == FMT_RGB) ? 3 : 4;
        n_bytes = run ? bpp : bpp * (int'(n_minus1) + 1);
        send_byte({run, n_minus1});
        repeat (n_bytes) send_byte(random_byte());
    endtask

    task automatic wait_quiet();
        stream_if.valid <= 1'b0;
        while (sb.expected_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= addr;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        sb.set_reg(addr, data);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [FORMAT_W-1:0] fmt, input logic [PIXELS_W-1:0] size);
        wait_quiet();
        if ($urandom_range(1) == 0)
        begin
            cfg_write(CFG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
            cfg_write(CFG_IMAGE_PIXELS, size);
        end
        else
        begin
            cfg_write(CFG_IMAGE_PIXELS, size);
            cfg_write(CFG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
        end
    endtask

    initial
    begin
        #1_000_000;
        $display("timeout: %0d pixels still expected", sb.expected_pixels.size());
        $display("tga_rle_pixel_decoder_tb: done, errors");
        $finish;
    end

    initial
    begin
        bit                  run;
        logic [6:0]          n_minus1;
        int                  phase;
        int                  phase_end;
        logic [FORMAT_W-1:0] fmt;
        logic [PIXELS_W-1:0] size;

        rst_n                 = 1'b0;
        stream_if.valid       = 1'b0;
        stream_if.stream_byte = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.addr           = '0;
        cfg_if.data           = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: a full-length run clipped to a one-pixel image, then a raw pixel.
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);

        // With an image size of zero every pixel is dropped.
        configure(FMT_MONO, '0);
        send_byte(8'h81);
        send_byte(8'h5A);

        configure(FMT_RGBA, 32'hFFFF_FFFF);
        send_byte(8'h00);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h78);

        configure(FMT_CODE3, SIZE_MAX);
        send_byte(8'h80);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hC3);
        send_byte(8'h3C);

        // The format changes inside a pixel, then the size drops below what was emitted.
        configure(FMT_RGB, 32'd5);
        send_byte(8'h02);
        send_byte(8'h11);
        send_byte(8'h22);
        wait_quiet();
        cfg_write(CFG_PIXEL_FORMAT, CFG_DATA_W'(FMT_MONO));
        send_byte(8'h33);
        wait_quiet();
        cfg_write(CFG_IMAGE_PIXELS, '0);
        send_byte(8'h44);
        send_byte(8'h55);

        phase = 0;
        while (sb.bytes_seen < STIMULUS_BYTES)
        begin
            idle_pct = (phase >= 12 && phase < 18) ? 0 : 10;
            fmt = FORMAT_W'($urandom_range(3));
            case ($urandom_range(19))
                0: size = '0;
                1: size = 32'd1;
                2: size = SIZE_MAX;
                3: size = 32'hFFFF_FFFF;
                4: size = $urandom();
                default: size = $urandom_range(1, 300);
            endcase
            configure(fmt, size);
            phase_end = sb.bytes_seen + $urandom_range(20, 90);
            while (sb.bytes_seen < phase_end)
            begin
                if ($urandom_range(99) < 12)
                begin
                    repeat ($urandom_range(1, 5)) send_byte(random_byte());
                end
                else
                begin
                    run = $urandom_range(1);
                    case ($urandom_range(19))
                        0: n_minus1 = run ? 7'd127 : 7'd15;
                        1: n_minus1 = 7'd0;
                        2: n_minus1 = run ? 7'($urandom_range(127)) : 7'($urandom_range(31));
                        default: n_minus1 = 7'($urandom_range(7));
                    endcase
                    send_packet(run, n_minus1);
                end
            end
            phase++;
        end

        wait_quiet();
        $display("covered %0d stream bytes, %0d decoded pixels, %0d register writes",
                 sb.bytes_seen, sb.pixels_checked, sb.reg_writes);
        $display("over all four format codes and image sizes from zero to the full 32 bits");
        if (sb.errors == 0)
        begin
            $display("tga_rle_pixel_decoder_tb: done, clean");
        end
        else
        begin
            $display("tga_rle_pixel_decoder_tb: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
design/tga_rle_pkg.sv
design/tga_rle_if.sv
design/tga_rle_cfg_regs.sv
design/tga_rle_core.sv
design/tga_rle_out_stage.sv
design/tga_rle_pixel_decoder.sv
tb/sv/tga_rle_pixel_decoder_sb_pkg.sv
tb/sv/tga_rle_pixel_decoder_tb.sv
